// ----- hw/rtl/lnsp_pkg.sv -----
// Shared types, constants and tables for the scan packet parser.
package lnsp_pkg;

    // Default depth of the packet queue between framer and formatter
    localparam int LNSP_QDEPTH = 2;

    // Reset value of the quality floor register
    localparam logic [6:0] QUAL_FLOOR_RST = 7'd10;

    // Quality scaling: percent = floor(QualScale * raw / QualRawMax)
    localparam int QualScale  = 100;
    localparam int QualRawMax = 63;

    // Rounding of the Q6 angle to whole degrees
    localparam int ANGLE_FRAC = 6;
    localparam logic [15:0] ANGLE_HALF = 16'd32;

    // Byte position the framer expects next
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_B1   = 3'd1,
        PH_B2   = 3'd2,
        PH_B3   = 3'd3,
        PH_B4   = 3'd4
    } phase_t;

    // One framed packet, raw fields
    typedef struct packed {
        logic        new_scan;
        logic [5:0]  qual_raw;
        logic [14:0] angle_q6;
        logic [15:0] dist_qmm;
    } pkt_t;

    // One formatted result, last field in the lowest bits
    typedef struct packed {
        logic [15:0] distance_qmm;
        logic [9:0]  angle_deg;
        logic [6:0]  quality_pct;
        logic        new_scan;
        logic        meas_valid;
    } result_t;

    // Queue status seen by the framer, the formatter and the top level
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Quality lookup, built at elaboration
    typedef logic [63:0][6:0] qual_tbl_t;

    function automatic qual_tbl_t build_qual_table();
        qual_tbl_t tbl;
        for (int i = 0; i < 64; i++) begin
            tbl[i] = 7'((QualScale * i) / QualRawMax);
        end
        return tbl;
    endfunction

    localparam qual_tbl_t QUAL_TABLE = build_qual_table();

endpackage

// ----- hw/rtl/lnsp_front.sv -----
// Byte framer: hunts packet starts and collects five-byte scan packets.
module lnsp_front import lnsp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] rx_byte
    input  qstat_t     q_stat,
    output logic       push,
    output pkt_t       push_pkt
);

    phase_t     phase_reg, phase_next;
    logic [7:0] b0_reg, b1_reg, b2_reg, b3_reg;
    logic       accept;

    // Only the last byte needs room in the queue
    assign s_tready = (phase_reg != PH_B4) || !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    // Phase register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Packet byte capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            unique case (phase_reg)
                PH_B1:   b1_reg <= s_tdata;
                PH_B2:   b2_reg <= s_tdata;
                PH_B3:   b3_reg <= s_tdata;
                PH_B4:   ;
                default: b0_reg <= s_tdata;
            endcase
        end
    end

    // Next phase and packet push
    always_comb begin
        phase_next = phase_reg;
        push       = 1'b0;
        if (accept) begin
            unique case (phase_reg)
                PH_B1:   phase_next = s_tdata[0] ? PH_B2 : PH_HUNT;
                PH_B2:   phase_next = PH_B3;
                PH_B3:   phase_next = PH_B4;
                PH_B4: begin
                    phase_next = PH_HUNT;
                    push       = 1'b1;
                end
                default: phase_next = (s_tdata[0] ^ s_tdata[1]) ? PH_B1 : PH_HUNT;
            endcase
        end
    end

    assign push_pkt.new_scan = b0_reg[0];
    assign push_pkt.qual_raw = b0_reg[7:2];
    assign push_pkt.angle_q6 = {b2_reg, b1_reg[7:1]};
    assign push_pkt.dist_qmm = {s_tdata, b3_reg};

endmodule

// ----- hw/rtl/lnsp_queue.sv -----
// Short packet queue between framer and formatter.
module lnsp_queue import lnsp_pkg::*; #(
    parameter int DEPTH = LNSP_QDEPTH
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  pkt_t   push_pkt,
    input  logic   pop,
    output pkt_t   head_pkt,
    output qstat_t q_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    pkt_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_pkt;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    assign head_pkt     = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

// ----- hw/rtl/lnsp_back.sv -----
// Result formatter: quality, validity, rounded angle; holds the output register.
module lnsp_back import lnsp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [6:0]  quality_floor,
    input  pkt_t        head_pkt,
    input  qstat_t      q_stat,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata
);

    logic        m_valid_reg;
    result_t     res_reg, res_next;
    logic [6:0]  quality;
    logic        meas_ok;
    logic [15:0] angle_sum;

    // Load a new result when the output stage is free or being drained
    assign pop = !q_stat.empty && (!m_valid_reg || m_tready);

    // Formatting of the queue head
    always_comb begin
        quality   = QUAL_TABLE[head_pkt.qual_raw];
        meas_ok   = quality > quality_floor;
        angle_sum = {1'b0, head_pkt.angle_q6} + ANGLE_HALF;

        res_next.meas_valid   = meas_ok;
        res_next.new_scan     = head_pkt.new_scan;
        res_next.quality_pct  = quality;
        res_next.angle_deg    = meas_ok ? angle_sum[15:ANGLE_FRAC] : '0;
        res_next.distance_qmm = meas_ok ? head_pkt.dist_qmm : '0;
    end

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, res_reg};

endmodule

// ----- hw/rtl/lidar_normal_scan_parser.sv -----
// Top level of the five-byte scan packet parser.
//
// Takes one serial byte per transaction on the s_ stream, frames five-byte scan
// packets (start byte with bit 0 and bit 1 differing, second byte with bit 0
// set, else both dropped) and emits one result per packet on the m_ stream:
// validity, start-of-rotation flag, quality in percent, angle rounded to whole
// degrees and distance in quarter millimetres (angle and distance zero when
// quality is not above quality_floor). A byte is taken every cycle; the last
// byte of a packet waits only when the packet queue (QDEPTH entries) is full,
// and a result reaches m_ through the queue entry and the output register when
// the output is free. quality_floor resets to 10; the user must write it over
// the cfg_ channel only while no packet is in flight; the block does not check.
module lidar_normal_scan_parser import lnsp_pkg::*; #(
    parameter int QDEPTH = LNSP_QDEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [0] meas_valid, [1] new_scan, [8:2] quality_pct,
                                    // [18:9] angle_deg, [34:19] distance_qmm, [39:35] zero
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data    // [6:0] quality_floor
);

    logic [6:0] floor_reg;
    logic       push, pop;
    pkt_t       push_pkt, head_pkt;
    qstat_t     q_stat;

    // Quality floor register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= QUAL_FLOOR_RST;
        end else if (cfg_valid && cfg_ready) begin
            floor_reg <= cfg_data;
        end
    end

    lnsp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .push     (push),
        .push_pkt (push_pkt)
    );

    lnsp_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_pkt (push_pkt),
        .pop      (pop),
        .head_pkt (head_pkt),
        .q_stat   (q_stat)
    );

    lnsp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .quality_floor (floor_reg),
        .head_pkt      (head_pkt),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    // Queue never reports full and empty together
    a_qstat: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("packet queue full and empty at once");

    // Input stalls only when the queue has no room
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_stat.full)
        else $error("input stalled with queue space left");

    // Invalid measurements carry zero angle and distance
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[34:9] == '0))
        else $error("invalid measurement with nonzero angle or distance");

    // Quality stays within percent range
    a_qual: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:2] <= 7'd100))
        else $error("quality above 100 percent");

endmodule
